// File: hdl/atrp_pkg.sv
// atrp_pkg: shared widths, fixed-point formats, angle table and gain constant
// for the accelerometer tilt pipeline. No dependencies.

package atrp_pkg;

   // field widths of the sample and result transfers
   localparam int IN_W    = 16;
   localparam int ROLL_W  = 16;
   localparam int PITCH_W = 15;

   // data path: samples scaled by 2^16, magnitude growth stays below 2^34
   localparam int DATA_SHIFT = 16;
   localparam int X_W        = 36;

   // angles in 2^-24 degree, roll plus half-turn offset stays below 2^33
   localparam int ANG_W    = 34;
   localparam int ANG_BITS = 24;
   localparam int TAB_LEN  = 24;

   // gain compensation, q30, multiplied in two 17-bit halves
   localparam int GAIN_W    = 30;
   localparam int GAIN_FRAC = 30;
   localparam int SPLIT     = 17;

   localparam int HALF_TURN_DEG    = 180;
   localparam int QUARTER_TURN_DEG = 90;

   typedef logic signed [X_W-1:0]   data_type;
   typedef logic signed [ANG_W-1:0] angle_type;

   // vector and angle accumulator carried between iterations
   typedef struct packed {
      logic      zero;
      data_type  x;
      data_type  y;
      angle_type ang;
   } cordic_type;

   // atan(2^-i) in degrees, scaled by 2^24
   function automatic angle_type atan_entry(input int idx);
      angle_type val;
      case (idx)
         0:  val = angle_type'(754974720);
         1:  val = angle_type'(445687602);
         2:  val = angle_type'(235489088);
         3:  val = angle_type'(119537938);
         4:  val = angle_type'(60000934);
         5:  val = angle_type'(30029717);
         6:  val = angle_type'(15018523);
         7:  val = angle_type'(7509720);
         8:  val = angle_type'(3754917);
         9:  val = angle_type'(1877466);
         10: val = angle_type'(938734);
         11: val = angle_type'(469367);
         12: val = angle_type'(234684);
         13: val = angle_type'(117342);
         14: val = angle_type'(58671);
         15: val = angle_type'(29335);
         16: val = angle_type'(14668);
         17: val = angle_type'(7334);
         18: val = angle_type'(3667);
         19: val = angle_type'(1833);
         20: val = angle_type'(917);
         21: val = angle_type'(458);
         22: val = angle_type'(229);
         23: val = angle_type'(115);
         default: val = '0;
      endcase
      return val;
   endfunction

   // q30 inverse gain for a given number of iterations
   function automatic logic [GAIN_W-1:0] gain_q30(input int steps);
      int          n;
      logic [63:0] g;
      n = (steps > TAB_LEN) ? TAB_LEN : steps;
      g = 64'd652032874 + (64'd434688583 >> (2 * n));
      return g[GAIN_W-1:0];
   endfunction

endpackage

// File: hdl/atrp_if.sv
// atrp_if: valid/ready channel interfaces for accelerometer samples and
// tilt results. Depends on atrp_pkg.

interface atrp_req_if
   import atrp_pkg::*;
   ();
   logic                   valid;
   logic                   ready;
   logic signed [IN_W-1:0] accel_x;
   logic signed [IN_W-1:0] accel_y;
   logic signed [IN_W-1:0] accel_z;

   modport source (output valid, output accel_x, output accel_y, output accel_z,
                   input ready);
   modport sink (input valid, input accel_x, input accel_y, input accel_z,
                 output ready);
endinterface

interface atrp_rsp_if
   import atrp_pkg::*;
   ();
   logic                      valid;
   logic                      ready;
   logic signed [ROLL_W-1:0]  roll_angle;
   logic signed [PITCH_W-1:0] pitch_angle;

   modport source (output valid, output roll_angle, output pitch_angle, input ready);
   modport sink (input valid, input roll_angle, input pitch_angle, output ready);
endinterface

// File: hdl/atrp_cordic_stage.sv
// atrp_cordic_stage: one registered cordic vectoring iteration with a
// pass-through side field. Depends on atrp_pkg.

module atrp_cordic_stage
   import atrp_pkg::*;
#(
   parameter int STEP_IDX = 0,
   parameter int SIDE_W   = 1
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              enable,
   input  logic              in_valid,
   input  cordic_type        in_state,
   input  logic [SIDE_W-1:0] in_side,
   output logic              out_valid,
   output cordic_type        out_state,
   output logic [SIDE_W-1:0] out_side
);

   localparam angle_type STEP_ANG = atan_entry(STEP_IDX);

   data_type          x_cur;
   data_type          y_cur;
   angle_type         ang_cur;
   data_type          dx;
   data_type          dy;
   cordic_type        state_in;
   cordic_type        state_ff;
   logic [SIDE_W-1:0] side_ff;
   logic              valid_ff;

   // rotate towards the x axis, a zero vector passes unchanged
   always_comb begin
      x_cur    = in_state.x;
      y_cur    = in_state.y;
      ang_cur  = in_state.ang;
      dx       = y_cur >>> STEP_IDX;
      dy       = x_cur >>> STEP_IDX;
      state_in = in_state;
      if (!in_state.zero) begin
         if (!y_cur[X_W-1]) begin
            state_in.x   = x_cur + dx;
            state_in.y   = y_cur - dy;
            state_in.ang = ang_cur + STEP_ANG;
         end else begin
            state_in.x   = x_cur - dx;
            state_in.y   = y_cur + dy;
            state_in.ang = ang_cur - STEP_ANG;
         end
      end
   end

   // valid bit
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (enable) begin
         valid_ff <= in_valid;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (enable) begin
         state_ff <= state_in;
         side_ff  <= in_side;
      end
   end

   assign out_valid = valid_ff;
   assign out_state = state_ff;
   assign out_side  = side_ff;

endmodule

// File: hdl/atrp_gain.sv
// atrp_gain: two-stage gain compensation of the cordic magnitude, split into
// two 17 x 30 bit partial products. Depends on atrp_pkg.

module atrp_gain
   import atrp_pkg::*;
#(
   parameter int STEPS  = 16,
   parameter int SIDE_W = 1
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              enable,
   input  logic              in_valid,
   input  data_type          in_x,
   input  logic [SIDE_W-1:0] in_side,
   output logic              out_valid,
   output data_type          out_mag,
   output logic [SIDE_W-1:0] out_side
);

   localparam int                PART_W = SPLIT + GAIN_W;
   localparam int                PROD_W = 2 * SPLIT + GAIN_W;
   localparam logic [GAIN_W-1:0] STEP_GAIN = gain_q30(STEPS);

   logic [PART_W-1:0] lo_in;
   logic [PART_W-1:0] hi_in;
   logic [PART_W-1:0] lo_ff;
   logic [PART_W-1:0] hi_ff;
   logic [PROD_W-1:0] sum;
   data_type          mag_in;
   data_type          mag_ff;
   logic [SIDE_W-1:0] side_a_ff;
   logic [SIDE_W-1:0] side_b_ff;
   logic              valid_a_ff;
   logic              valid_b_ff;

   // partial products, magnitude is non-negative and below 2^34
   assign lo_in = PART_W'(in_x[SPLIT-1:0]) * PART_W'(STEP_GAIN);
   assign hi_in = PART_W'(in_x[2*SPLIT-1:SPLIT]) * PART_W'(STEP_GAIN);

   // recombine and drop the q30 fraction
   assign sum    = {hi_ff, SPLIT'(0)} + PROD_W'(lo_ff);
   assign mag_in = data_type'({{(X_W - PROD_W + GAIN_FRAC){1'b0}}, sum[PROD_W-1:GAIN_FRAC]});

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_a_ff <= 1'b0;
         valid_b_ff <= 1'b0;
      end else if (enable) begin
         valid_a_ff <= in_valid;
         valid_b_ff <= valid_a_ff;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (enable) begin
         lo_ff     <= lo_in;
         hi_ff     <= hi_in;
         side_a_ff <= in_side;
         mag_ff    <= mag_in;
         side_b_ff <= side_a_ff;
      end
   end

   assign out_valid = valid_b_ff;
   assign out_mag   = mag_ff;
   assign out_side  = side_b_ff;

endmodule

// File: hdl/accel_tilt_roll_pitch_unit.sv
// accel_tilt_roll_pitch_unit: top level of the accelerometer tilt pipeline.
// Depends on atrp_pkg, atrp_if, atrp_cordic_stage and atrp_gain.
//
// Usage:
//   req carries one raw three-axis sample (accel_x, accel_y, accel_z, signed
//   16-bit counts); rsp carries roll_angle = atan2(y, z) and
//   pitch_angle = atan2(-x, sqrt(y^2 + z^2)) in 1/2^ANGLE_FRAC_BITS degree.
//   A transfer happens when valid and ready are both high.
//   Every sample gives exactly one result, in order.
//   The pipeline has 2 * CORDIC_STEPS + 4 register stages: one input stage, one
//   register per roll iteration, two gain multiply stages, one register per
//   pitch iteration and one rounding and clamp stage.
//   Throughput is one sample per cycle while the receiver does not stall;
//   each iteration has its own stage.
//   When the receiver stalls with a result waiting, the whole pipeline holds
//   and req.ready drops; nothing is lost or repeated. Empty stages travel as
//   bubbles with their valid bit low.
//   Reset is synchronous and clears all valid bits; the block keeps no state
//   between samples and needs no set-up.

module accel_tilt_roll_pitch_unit
   import atrp_pkg::*;
#(
   parameter int CORDIC_STEPS    = 16,
   parameter int ANGLE_FRAC_BITS = 7
) (
   input logic        clock,
   input logic        reset,
   atrp_req_if.sink   req,
   atrp_rsp_if.source rsp
);

   localparam int        SHIFT      = ANG_BITS - ANGLE_FRAC_BITS;
   localparam angle_type HALF_LSB   = angle_type'(longint'(1) << (SHIFT - 1));
   localparam angle_type HALF_TURN  = angle_type'(longint'(HALF_TURN_DEG) << ANG_BITS);
   localparam angle_type ROLL_LIM   = angle_type'(longint'(HALF_TURN_DEG) << ANGLE_FRAC_BITS);
   localparam angle_type PITCH_LIM  = angle_type'(longint'(QUARTER_TURN_DEG) << ANGLE_FRAC_BITS);
   localparam int        ROLL_SIDE  = IN_W;
   localparam int        GAIN_SIDE  = ANG_W + IN_W;
   localparam int        PITCH_SIDE = ANG_W;

   logic pipe_en;

   // input stage
   data_type             az_s;
   data_type             ay_s;
   cordic_type           pre_in;
   cordic_type           pre_ff;
   logic [IN_W-1:0]      pre_ax_ff;
   logic                 pre_valid_ff;

   // roll chain
   cordic_type           roll_state [CORDIC_STEPS+1];
   logic [ROLL_SIDE-1:0] roll_side  [CORDIC_STEPS+1];
   logic                 roll_valid [CORDIC_STEPS+1];

   // gain stage
   data_type             mag;
   logic [GAIN_SIDE-1:0] gain_side;
   logic                 gain_valid;
   logic signed [IN_W-1:0] gain_ax;
   data_type             ax_s;

   // pitch chain
   cordic_type            pitch_state [CORDIC_STEPS+1];
   logic [PITCH_SIDE-1:0] pitch_side  [CORDIC_STEPS+1];
   logic                  pitch_valid [CORDIC_STEPS+1];

   // output stage
   angle_type                 roll_ang;
   angle_type                 pitch_ang;
   angle_type                 roll_r;
   angle_type                 pitch_r;
   angle_type                 roll_c;
   angle_type                 pitch_c;
   logic signed [ROLL_W-1:0]  roll_in;
   logic signed [PITCH_W-1:0] pitch_in;
   logic signed [ROLL_W-1:0]  roll_ff;
   logic signed [PITCH_W-1:0] pitch_ff;
   logic                      out_valid_ff;

   // the pipeline moves unless a finished result is held back
   assign pipe_en   = !out_valid_ff || rsp.ready;
   assign req.ready = pipe_en;

   // scale samples, fold negative z into the right half-plane
   always_comb begin
      az_s = {{(X_W - IN_W - DATA_SHIFT){req.accel_z[IN_W-1]}}, req.accel_z,
              DATA_SHIFT'(0)};
      ay_s = {{(X_W - IN_W - DATA_SHIFT){req.accel_y[IN_W-1]}}, req.accel_y,
              DATA_SHIFT'(0)};
      pre_in.zero = (req.accel_z == '0) && (req.accel_y == '0);
      if (req.accel_z[IN_W-1]) begin
         pre_in.x   = -az_s;
         pre_in.y   = -ay_s;
         pre_in.ang = req.accel_y[IN_W-1] ? -HALF_TURN : HALF_TURN;
      end else begin
         pre_in.x   = az_s;
         pre_in.y   = ay_s;
         pre_in.ang = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pre_valid_ff <= 1'b0;
      end else if (pipe_en) begin
         pre_valid_ff <= req.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         pre_ff    <= pre_in;
         pre_ax_ff <= req.accel_x;
      end
   end

   // roll vectoring, x carried alongside
   assign roll_state[0] = pre_ff;
   assign roll_side[0]  = pre_ax_ff;
   assign roll_valid[0] = pre_valid_ff;

   for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_roll
      atrp_cordic_stage #(
         .STEP_IDX (i),
         .SIDE_W   (ROLL_SIDE)
      ) u_stage (
         .clock     (clock),
         .reset     (reset),
         .enable    (pipe_en),
         .in_valid  (roll_valid[i]),
         .in_state  (roll_state[i]),
         .in_side   (roll_side[i]),
         .out_valid (roll_valid[i+1]),
         .out_state (roll_state[i+1]),
         .out_side  (roll_side[i+1])
      );
   end

   // gain compensation of the y-z magnitude
   atrp_gain #(
      .STEPS  (CORDIC_STEPS),
      .SIDE_W (GAIN_SIDE)
   ) u_gain (
      .clock     (clock),
      .reset     (reset),
      .enable    (pipe_en),
      .in_valid  (roll_valid[CORDIC_STEPS]),
      .in_x      (roll_state[CORDIC_STEPS].x),
      .in_side   ({roll_state[CORDIC_STEPS].ang, roll_side[CORDIC_STEPS]}),
      .out_valid (gain_valid),
      .out_mag   (mag),
      .out_side  (gain_side)
   );

   // pitch vector is (magnitude, -x)
   assign gain_ax = gain_side[IN_W-1:0];
   assign ax_s    = {{(X_W - IN_W - DATA_SHIFT){gain_ax[IN_W-1]}}, gain_ax, DATA_SHIFT'(0)};

   always_comb begin
      pitch_state[0].zero = (mag == '0) && (gain_ax == '0);
      pitch_state[0].x    = mag;
      pitch_state[0].y    = -ax_s;
      pitch_state[0].ang  = '0;
   end
   assign pitch_side[0]  = gain_side[GAIN_SIDE-1:IN_W];
   assign pitch_valid[0] = gain_valid;

   for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_pitch
      atrp_cordic_stage #(
         .STEP_IDX (i),
         .SIDE_W   (PITCH_SIDE)
      ) u_stage (
         .clock     (clock),
         .reset     (reset),
         .enable    (pipe_en),
         .in_valid  (pitch_valid[i]),
         .in_state  (pitch_state[i]),
         .in_side   (pitch_side[i]),
         .out_valid (pitch_valid[i+1]),
         .out_state (pitch_state[i+1]),
         .out_side  (pitch_side[i+1])
      );
   end

   // round half up, clamp, cut to field width
   always_comb begin
      roll_ang  = pitch_side[CORDIC_STEPS];
      pitch_ang = pitch_state[CORDIC_STEPS].ang;
      roll_r    = (roll_ang + HALF_LSB) >>> SHIFT;
      pitch_r   = (pitch_ang + HALF_LSB) >>> SHIFT;
      roll_c    = roll_r;
      if (roll_r > ROLL_LIM) begin
         roll_c = ROLL_LIM;
      end else if (roll_r < -ROLL_LIM) begin
         roll_c = -ROLL_LIM;
      end
      pitch_c = pitch_r;
      if (pitch_r > PITCH_LIM) begin
         pitch_c = PITCH_LIM;
      end else if (pitch_r < -PITCH_LIM) begin
         pitch_c = -PITCH_LIM;
      end
      roll_in  = roll_c[ROLL_W-1:0];
      pitch_in = pitch_c[PITCH_W-1:0];
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (pipe_en) begin
         out_valid_ff <= pitch_valid[CORDIC_STEPS];
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         roll_ff  <= roll_in;
         pitch_ff <= pitch_in;
      end
   end

   assign rsp.valid       = out_valid_ff;
   assign rsp.roll_angle  = roll_ff;
   assign rsp.pitch_angle = pitch_ff;

endmodule

// File: tb/accel_tilt_roll_pitch_checker.sv
// accel_tilt_roll_pitch_checker: watches the sample and result channels, works out the
// expected roll and pitch of every sample and compares them with the results in order.
// Depends on atrp_pkg and atrp_if.

module accel_tilt_roll_pitch_checker
   import atrp_pkg::*;
#(
   parameter int CORDIC_STEPS    = 16,
   parameter int ANGLE_FRAC_BITS = 7
) (
   input  logic clock,
   input  logic reset,
   atrp_req_if  req,
   atrp_rsp_if  rsp,
   output int   mismatch_count,
   output int   results_owed
);

   typedef struct packed {
      logic signed [ROLL_W-1:0]  roll;
      logic signed [PITCH_W-1:0] pitch;
   } tilt_type;

   // atan(2^-i) in degrees, 2^-24 degree units, rounded to nearest
   localparam longint ATAN_Q24 [0:23] = '{
      754974720, 445687602, 235489088, 119537938, 60000934, 30029717,
      15018523, 7509720, 3754917, 1877466, 938734, 469367,
      234684, 117342, 58671, 29335, 14668, 7334,
      3667, 1833, 917, 458, 229, 115
   };
   localparam int     STEPS      = (CORDIC_STEPS > 24) ? 24 : CORDIC_STEPS;
   localparam longint COUNT_UNIT = 65536;

   tilt_type angle_queue[$];
   tilt_type want;

   // vectoring rotation: angle of (vx, vy) with vx >= 0, plus the raw final x
   function automatic longint vector_angle(input longint vx, input longint vy,
                                           output longint x_end);
      longint acc;
      longint dx;
      longint dy;
      acc = 0;
      if (vx == 0 && vy == 0) begin
         x_end = 0;
         return 0;
      end
      for (int i = 0; i < STEPS; i++) begin
         dx = vy >>> i;
         dy = vx >>> i;
         if (vy >= 0) begin
            vx  = vx + dx;
            vy  = vy - dy;
            acc = acc + ATAN_Q24[i];
         end else begin
            vx  = vx - dx;
            vy  = vy + dy;
            acc = acc - ATAN_Q24[i];
         end
      end
      x_end = vx;
      return acc;
   endfunction

   // round half up to the output format, then clamp to +-limit_deg
   function automatic longint round_clamp(input longint ang, input longint limit_deg);
      int     sh;
      longint r;
      longint lim;
      sh  = 24 - ANGLE_FRAC_BITS;
      r   = (ang + (longint'(1) <<< (sh - 1))) >>> sh;
      lim = limit_deg * (longint'(1) <<< ANGLE_FRAC_BITS);
      if (r > lim)
         r = lim;
      if (r < -lim)
         r = -lim;
      return r;
   endfunction

   // roll from (z, y), then pitch from (compensated magnitude, -x)
   function automatic tilt_type tilt_of_sample(input logic signed [IN_W-1:0] ax,
                                               input logic signed [IN_W-1:0] ay,
                                               input logic signed [IN_W-1:0] az);
      longint            sx;
      longint            sy;
      longint            sz;
      longint            vx;
      longint            vy;
      longint            offset;
      longint            x_end;
      longint            roll_q24;
      longint            pitch_q24;
      longint            magnitude;
      longint            r;
      longint unsigned   gain;
      tilt_type          t;
      sx     = longint'(ax) * COUNT_UNIT;
      sy     = longint'(ay) * COUNT_UNIT;
      sz     = longint'(az) * COUNT_UNIT;
      vx     = sz;
      vy     = sy;
      offset = 0;
      gain   = 64'd652032874 + (64'd434688583 >> (2 * STEPS));
      // negative z: fold into the right half-plane, add or take off a half turn
      if (vx < 0) begin
         vx     = -vx;
         vy     = -vy;
         offset = longint'(HALF_TURN_DEG) <<< ANG_BITS;
         if (sy < 0)
            offset = -offset;
      end
      roll_q24  = vector_angle(vx, vy, x_end) + offset;
      magnitude = longint'((longint'(unsigned'(x_end)) * gain) >> 30);
      pitch_q24 = vector_angle(magnitude, -sx, x_end);
      r       = round_clamp(roll_q24, HALF_TURN_DEG);
      t.roll  = r[ROLL_W-1:0];
      r       = round_clamp(pitch_q24, QUARTER_TURN_DEG);
      t.pitch = r[PITCH_W-1:0];
      return t;
   endfunction

   initial begin
      mismatch_count = 0;
      results_owed   = 0;
   end

   // result transfers are checked before the sample of the same edge is queued
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp.valid && rsp.ready) begin
            if (angle_queue.size() == 0) begin
               mismatch_count++;
               $display("%0t: result with none expected, roll %0d pitch %0d",
                        $time, rsp.roll_angle, rsp.pitch_angle);
            end else begin
               want = angle_queue.pop_front();
               if (rsp.roll_angle !== want.roll) begin
                  mismatch_count++;
                  $display("%0t: roll_angle expected %0d, actual %0d",
                           $time, want.roll, rsp.roll_angle);
               end
               if (rsp.pitch_angle !== want.pitch) begin
                  mismatch_count++;
                  $display("%0t: pitch_angle expected %0d, actual %0d",
                           $time, want.pitch, rsp.pitch_angle);
               end
            end
         end
         if (req.valid && req.ready)
            angle_queue.push_back(tilt_of_sample(req.accel_x, req.accel_y, req.accel_z));
         results_owed = angle_queue.size();
      end
   end

endmodule

// File: tb/accel_tilt_roll_pitch_unit_tb.sv
// accel_tilt_roll_pitch_unit_tb: drives accelerometer samples into the tilt unit,
// stalls the result side at random and gives the verdict from the checker's count.
// Depends on atrp_pkg, atrp_if, accel_tilt_roll_pitch_unit and accel_tilt_roll_pitch_checker.

module accel_tilt_roll_pitch_unit_tb
   import atrp_pkg::*;
   ();

   localparam int CORDIC_STEPS    = 16;
   localparam int ANGLE_FRAC_BITS = 7;
   localparam int LATENCY         = 2 * CORDIC_STEPS + 4;
   localparam int RANDOM_SAMPLES  = 1530;
   localparam int CALM_TAIL       = 200;

   typedef logic signed [IN_W-1:0] count_type;

   logic clock = 1'b0;
   logic reset;
   bit   gaps_on   = 1'b0;
   bit   stalls_on = 1'b0;
   int   mismatch_count;
   int   results_owed;

   atrp_req_if req ();
   atrp_rsp_if rsp ();

   accel_tilt_roll_pitch_unit #(
      .CORDIC_STEPS   (CORDIC_STEPS),
      .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req  (req),
      .rsp  (rsp)
   );

   accel_tilt_roll_pitch_checker #(
      .CORDIC_STEPS   (CORDIC_STEPS),
      .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)
   ) angle_check (
      .clock         (clock),
      .reset         (reset),
      .req           (req),
      .rsp           (rsp),
      .mismatch_count(mismatch_count),
      .results_owed  (results_owed)
   );

   // 8-unit clock
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // one sample transfer, then possibly a burst of idle cycles
   task automatic send_sample(input count_type x, input count_type y, input count_type z);
      req.valid   <= 1'b1;
      req.accel_x <= x;
      req.accel_y <= y;
      req.accel_z <= z;
      @(posedge clock);
      while (!req.ready)
         @(posedge clock);
      if (gaps_on && $urandom_range(0, 3) == 0) begin
         req.valid <= 1'b0;
         repeat ($urandom_range(1, 15))
            @(posedge clock);
      end
   endtask

   // mostly full-range counts, with zeros, rails and small values mixed in
   function automatic count_type random_count();
      count_type c;
      case ($urandom_range(0, 9))
         0:       c = '0;
         1:       c = $urandom_range(0, 1) ? count_type'(32767) : count_type'(-32768);
         2, 3:    c = count_type'($urandom_range(0, 128)) - count_type'(64);
         4:       c = count_type'($urandom_range(0, 4)) - count_type'(2);
         default: c = count_type'($urandom);
      endcase
      return c;
   endfunction

   // result-side back-pressure in bursts
   initial begin
      rsp.ready <= 1'b1;
      forever begin
         @(posedge clock);
         if (stalls_on && $urandom_range(0, 5) == 0) begin
            rsp.ready <= 1'b0;
            repeat ($urandom_range(1, 15))
               @(posedge clock);
            rsp.ready <= 1'b1;
         end
      end
   end

   // stimulus and verdict
   initial begin
      req.valid   <= 1'b0;
      req.accel_x <= '0;
      req.accel_y <= '0;
      req.accel_z <= '0;
      reset       <= 1'b1;
      repeat (3)
         @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: zero vector, half-turn folding, vertical gravity, rails
      send_sample(0, 0, 0);
      send_sample(0, 0, -32768);
      send_sample(0, 0, -1);
      send_sample(0, -1, -1);
      send_sample(0, 1, -1);
      send_sample(0, -32768, -32768);
      send_sample(0, 32767, -32768);
      send_sample(0, 0, 32767);
      send_sample(0, 32767, 0);
      send_sample(0, -32768, 0);
      send_sample(-32768, 0, 0);
      send_sample(32767, 0, 0);
      send_sample(1, 0, 0);
      send_sample(-1, 0, 0);
      send_sample(32767, 32767, 32767);
      send_sample(-32768, -32768, -32768);
      send_sample(-32768, 32767, -32768);
      send_sample(32767, -32768, 32767);
      send_sample(1, 1, 1);
      send_sample(-1, -1, 1);
      send_sample(16384, -5, 16384);
      send_sample(-7, 12000, -9000);

      // random samples, idling switched per block, quiet at the end
      for (int n = 0; n < RANDOM_SAMPLES; n++) begin
         if (n % 100 == 0) begin
            gaps_on   = (n < RANDOM_SAMPLES - CALM_TAIL) && ($urandom_range(0, 2) != 0);
            stalls_on = (n < RANDOM_SAMPLES - CALM_TAIL) && ($urandom_range(0, 2) != 0);
         end
         send_sample(random_count(), random_count(), random_count());
      end
      gaps_on   = 1'b0;
      stalls_on = 1'b0;
      req.valid <= 1'b0;

      // drain, then let the pipeline settle
      while (results_owed != 0)
         @(posedge clock);
      repeat (LATENCY + 8)
         @(posedge clock);

      if (mismatch_count == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

   // run limit
   initial begin
      #(8 * 400000);
      $display("tb: failure");
      $finish;
   end

endmodule
